// ===== src/fdr_pkg.sv =====
package fdr_pkg;

  localparam int TAPS       = 64;
  localparam int HALF_TAPS  = TAPS / 2;
  localparam int PHASE_W    = 25;
  localparam int REG_W      = 24;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 12;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 40;
  localparam int SUM_W      = 48;

  localparam logic [0:0] REG_RAW_RATE_STEP     = 1'd0;
  localparam logic [0:0] REG_SOURCE_CLOCK_RATE = 1'd1;

  localparam logic [REG_W-1:0] RAW_RATE_STEP_RESET     = 24'd192000;
  localparam logic [REG_W-1:0] SOURCE_CLOCK_RATE_RESET = 24'd1789773;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_acc;   // start a new FIR output
    logic mac;         // multiply-accumulate one tap
    logic fir_done;    // round, saturate and store one output
    logic clear_sum;   // start a new block
    logic take_mean;   // latch the block mean
    logic emit_load;   // load output register from block store
    logic copy_rd;     // history copy: read source
    logic copy_wr;     // history copy: write destination
  } fdr_cmd_t;

  // Symmetric low-pass, Q0.15, taps 0..32; tap j>32 mirrors tap 64-j.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [5:0] j);
    logic [5:0] k;
    logic signed [COEF_W-1:0] c;
    k = (j <= 6'd32) ? j : 6'(7'd64 - {1'b0, j});
    case (k)
      6'd0:  c = 12'sd0;     6'd1:  c = 12'sd0;     6'd2:  c = -12'sd17;
      6'd3:  c = -12'sd36;   6'd4:  c = -12'sd56;   6'd5:  c = -12'sd74;
      6'd6:  c = -12'sd90;   6'd7:  c = -12'sd102;  6'd8:  c = -12'sd107;
      6'd9:  c = -12'sd104;  6'd10: c = -12'sd92;   6'd11: c = -12'sd70;
      6'd12: c = -12'sd36;   6'd13: c = 12'sd10;    6'd14: c = 12'sd69;
      6'd15: c = 12'sd141;   6'd16: c = 12'sd225;   6'd17: c = 12'sd320;
      6'd18: c = 12'sd425;   6'd19: c = 12'sd539;   6'd20: c = 12'sd659;
      6'd21: c = 12'sd784;   6'd22: c = 12'sd910;   6'd23: c = 12'sd1035;
      6'd24: c = 12'sd1157;  6'd25: c = 12'sd1273;  6'd26: c = 12'sd1379;
      6'd27: c = 12'sd1474;  6'd28: c = 12'sd1555;  6'd29: c = 12'sd1620;
      6'd30: c = 12'sd1668;  6'd31: c = 12'sd1697;  6'd32: c = 12'sd1707;
      default: c = 12'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/fdr_datapath.sv =====
module fdr_datapath
  import fdr_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 32,
  parameter int RAW_DEPTH     = 192,
  parameter int RAW_AW        = 8,
  parameter int BLK_AW        = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fdr_cmd_t                   cmd,
  // raw store write port (sample intake or history copy)
  input  logic                       raw_we,
  input  logic [RAW_AW-1:0]          raw_waddr,
  input  logic signed [SAMPLE_W-1:0] raw_wdata,
  input  logic                       raw_wsel_copy,
  input  logic [RAW_AW-1:0]          raw_raddr,
  input  logic                       raw_rvalid,
  input  logic [5:0]                 tap,
  input  logic [BLK_AW-1:0]          blk_addr,
  output logic signed [SAMPLE_W-1:0] sample_q
);

  localparam logic signed [SUM_W-1:0] HALF_BLK = SUM_W'(BLOCK_SAMPLES / 2);
  localparam logic signed [SUM_W-1:0] BLK_N    = SUM_W'(BLOCK_SAMPLES);
  localparam int MEAN_SH = 30;
  localparam logic [31:0] MEAN_RECIP =
    32'(((64'd1 << MEAN_SH) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES));

  logic signed [SAMPLE_W-1:0] raw_mem [RAW_DEPTH];
  logic signed [SAMPLE_W-1:0] blk_mem [BLOCK_SAMPLES];
  logic signed [SAMPLE_W-1:0] raw_q_r;
  logic                       raw_ok_r;
  logic [5:0]                 tap_r;
  logic                       mac_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_v_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    mean_r;
  logic signed [SAMPLE_W-1:0] blk_q_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [ACC_W-1:0]    y_full;
  logic signed [SUM_W-1:0]    diff;
  logic signed [SUM_W-1:0]    mean_nxt;
  logic signed [SUM_W-1:0]    mean_num;
  logic [SUM_W-1:0]           mean_mag;
  logic [55:0]                mean_prod;
  logic [SUM_W-1:0]           mean_q;
  logic signed [SAMPLE_W-1:0] wdata;

  always_comb begin
    wdata  = raw_wsel_copy ? raw_q_r : raw_wdata;
    y_full = (acc_r + ACC_W'(16384)) >>> 15;
    if (y_full > ACC_W'(32767)) y_sat = 16'sh7fff;
    else if (y_full < -ACC_W'(32768)) y_sat = 16'sh8000;
    else y_sat = y_full[SAMPLE_W-1:0];
    // floor division by the block length: divide the magnitude by a
    // reciprocal multiply, rounding towards minus infinity for a negative sum
    mean_num  = sum_r + HALF_BLK;
    mean_mag  = mean_num[SUM_W-1] ? (BLK_N - SUM_W'(1) - mean_num) : mean_num;
    mean_prod = 56'(mean_mag[23:0]) * 56'(MEAN_RECIP);
    mean_q    = SUM_W'(mean_prod >> MEAN_SH);
    mean_nxt  = mean_num[SUM_W-1] ? -$signed(mean_q) : $signed(mean_q);
    diff = SUM_W'(blk_q_r) - mean_r;
  end

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_waddr] <= wdata;
    raw_q_r <= raw_mem[raw_raddr];
    if (cmd.fir_done) blk_mem[blk_addr] <= y_sat;
    blk_q_r <= blk_mem[blk_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r    <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      mac_r    <= cmd.mac;
      prod_v_r <= mac_r;
    end
    raw_ok_r <= raw_rvalid;
    tap_r    <= tap;
    prod_r   <= (raw_ok_r ? raw_q_r : SAMPLE_W'(0)) * coef_at(tap_r);
    if (cmd.clear_acc) acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_r + ACC_W'(prod_r);
    if (cmd.clear_sum) sum_r <= '0;
    else if (cmd.fir_done) sum_r <= sum_r + SUM_W'(y_sat);
    if (cmd.take_mean) mean_r <= mean_nxt;
    if (cmd.emit_load) begin
      if (diff > SUM_W'(32767)) sample_r <= 16'sh7fff;
      else if (diff < -SUM_W'(32768)) sample_r <= 16'sh8000;
      else sample_r <= diff[SAMPLE_W-1:0];
    end
  end

  assign sample_q = sample_r;

endmodule

// ===== src/fdr_ctrl.sv =====
module fdr_ctrl
  import fdr_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 32,
  parameter int OVERSAMPLING  = 4,
  parameter int RAW_DEPTH     = 192,
  parameter int RAW_AW        = 8,
  parameter int BLK_AW        = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [REG_W-1:0]           raw_rate_step,
  input  logic [REG_W-1:0]           source_clock_rate,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_block_last,
  output fdr_cmd_t                   cmd,
  output logic                       raw_we,
  output logic [RAW_AW-1:0]          raw_waddr,
  output logic signed [SAMPLE_W-1:0] raw_wdata,
  output logic                       raw_wsel_copy,
  output logic [RAW_AW-1:0]          raw_raddr,
  output logic                       raw_rvalid,
  output logic [5:0]                 tap,
  output logic [BLK_AW-1:0]          blk_addr
);

  localparam int IDX_W  = RAW_AW + 12;
  localparam int WP_W   = RAW_AW + 1;
  localparam logic [WP_W-1:0] DEPTH_W = WP_W'(RAW_DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(RAW_DEPTH);
  localparam logic [IDX_W-1:0] SHIFT_I = IDX_W'(BLOCK_SAMPLES * OVERSAMPLING);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MEAN  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_COPY  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [WP_W-1:0]   wp_r;
  logic [RAW_AW-1:0] clr_r;
  logic [BLK_AW:0]   out_i_r;
  logic [6:0]        tap_r;
  logic [2:0]        cnt_r;
  logic              pend_r;
  logic              ov_r;
  logic              last_r;
  logic [PHASE_W:0]  ph;
  logic              store;
  logic [IDX_W-1:0]  ridx;
  logic              emit_go;

  assign ph    = {1'b0, phase_r} + (PHASE_W+1)'(raw_rate_step);
  assign store = ph >= (PHASE_W+1)'(source_clock_rate);
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_block_last = last_r;
  assign blk_addr = out_i_r[BLK_AW-1:0];
  assign tap = tap_r[5:0];
  assign emit_go = (state_r == ST_EMIT) && !pend_r && (!ov_r || out_ready)
                   && (out_i_r < (BLK_AW+1)'(BLOCK_SAMPLES));

  always_comb begin
    cmd = '0;
    raw_we = 1'b0;
    raw_waddr = wp_r[RAW_AW-1:0];
    raw_wdata = in_sample_in;
    raw_wsel_copy = 1'b0;
    ridx = IDX_W'(out_i_r) * IDX_W'(OVERSAMPLING) + IDX_W'(tap_r);
    raw_rvalid = ridx < DEPTH_I;
    raw_raddr = ridx[RAW_AW-1:0];
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        raw_we = 1'b1; raw_waddr = clr_r; raw_wdata = '0;
        if (clr_r == RAW_AW'(RAW_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && store) begin
          raw_we = wp_r < DEPTH_W;
          if (wp_r + WP_W'(1) >= DEPTH_W) begin
            state_nxt = ST_MAC; cmd.clear_acc = 1'b1; cmd.clear_sum = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd.mac = tap_r < 7'd64;
        if (tap_r == 7'd63) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt_r == 3'd3) cmd.fir_done = 1'b1;
        if (cnt_r == 3'd4) begin
          cmd.clear_acc = 1'b1;
          if (out_i_r == (BLK_AW+1)'(BLOCK_SAMPLES - 1)) state_nxt = ST_MEAN;
          else state_nxt = ST_MAC;
        end
      end
      ST_MEAN: begin
        cmd.take_mean = 1'b1; state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_load = pend_r;
        if (out_i_r == (BLK_AW+1)'(BLOCK_SAMPLES) && !pend_r && (!ov_r || out_ready))
          state_nxt = ST_COPY;
      end
      ST_COPY: begin
        // read source on the even cycle, write the previous tap's word on it too
        ridx = SHIFT_I + IDX_W'(tap_r);
        raw_raddr = ridx[RAW_AW-1:0];
        raw_wsel_copy = SHIFT_I + IDX_W'(tap_r - 7'd1) < DEPTH_I;
        raw_wdata = '0;
        raw_waddr = RAW_AW'(tap_r - 7'd1);
        raw_we = !cnt_r[0] && (tap_r != 7'd0) && (IDX_W'(tap_r - 7'd1) < DEPTH_I);
        if (cnt_r[0] && tap_r == 7'd64) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= '0;
      wp_r    <= WP_W'(HALF_TAPS);
      clr_r   <= '0;
      out_i_r <= '0;
      tap_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + RAW_AW'(1);
        ST_IDLE: begin
          if (in_valid) begin
            if (store) begin
              phase_r <= PHASE_W'(ph - (PHASE_W+1)'(source_clock_rate));
              wp_r <= wp_r + WP_W'(1);
            end else begin
              phase_r <= ph[PHASE_W-1:0];
            end
          end
          out_i_r <= '0; tap_r <= '0; cnt_r <= '0;
        end
        ST_MAC: begin
          tap_r <= tap_r + 7'd1; cnt_r <= '0;
        end
        ST_DRAIN: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            tap_r <= '0; cnt_r <= '0;
            out_i_r <= out_i_r + (BLK_AW+1)'(1);
            if (out_i_r == (BLK_AW+1)'(BLOCK_SAMPLES - 1)) out_i_r <= '0;
          end
        end
        ST_MEAN: begin
          out_i_r <= '0; pend_r <= 1'b0;
        end
        ST_EMIT: begin
          // blk_addr was presented last cycle; read data valid now
          if (pend_r) pend_r <= 1'b0;
          else if (emit_go) begin
            pend_r <= 1'b1;
          end
          if (pend_r) begin
            ov_r   <= 1'b1;
            last_r <= out_i_r == (BLK_AW+1)'(BLOCK_SAMPLES - 1);
            out_i_r <= out_i_r + (BLK_AW+1)'(1);
          end
          if (state_nxt == ST_COPY) begin
            tap_r <= '0; cnt_r <= '0; wp_r <= WP_W'(TAPS);
          end
        end
        ST_COPY: begin
          cnt_r <= {2'b0, ~cnt_r[0]};
          if (cnt_r[0]) tap_r <= tap_r + 7'd1;
        end
        default: ;
      endcase
    end
  end

  // An output is never overwritten before it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_last))
    else $error("output lost under stall");
  // No input is taken while a block is in flight.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  // The write position stays below the store depth while idle.
  a_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> wp_r < DEPTH_W)
    else $error("write position overrun");

endmodule

// ===== src/fir_decimating_resampler.sv =====
// Fractional-rate FIR decimator with block DC removal. Each transfer on the
// in_ channel is one source tick; a 25-bit phase accumulator decides whether
// the sample is written to the raw store. When the store fills, a 64-tap
// symmetric low-pass FIR is run every OVERSAMPLING raw positions on one
// shared multiplier, one tap per cycle, giving BLOCK_SAMPLES results; the
// rounded block mean is subtracted and the block leaves on the out_ channel
// with out_block_last on its final sample, then the newest 64 raw samples
// are copied to the front. While a block is processed in_ready is low.
// After reset a clearing pass zeroes the raw store before the first input
// is taken. Configuration registers: raw_rate_step at 0x0,
// source_clock_rate at 0x4.
module fir_decimating_resampler
  import fdr_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 32,
  parameter int OVERSAMPLING  = 4,
  parameter int RAW_DEPTH     = 192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_block_last
);

  localparam int RAW_AW = $clog2(RAW_DEPTH);
  localparam int BLK_AW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

  logic [REG_W-1:0] step_r, rate_r;
  fdr_cmd_t cmd;
  logic raw_we, raw_wsel_copy, raw_rvalid;
  logic [RAW_AW-1:0] raw_waddr, raw_raddr;
  logic signed [SAMPLE_W-1:0] raw_wdata;
  logic [5:0] tap;
  logic [BLK_AW-1:0] blk_addr;

  assign cfg_pready = 1'b1;

  // Register write on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= RAW_RATE_STEP_RESET;
      rate_r <= SOURCE_CLOCK_RATE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_RAW_RATE_STEP) step_r <= cfg_pwdata[REG_W-1:0];
      else rate_r <= cfg_pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_RAW_RATE_STEP:     cfg_prdata = {8'd0, step_r};
      REG_SOURCE_CLOCK_RATE: cfg_prdata = {8'd0, rate_r};
      default:               cfg_prdata = '0;
    endcase
  end

  fdr_ctrl #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES), .OVERSAMPLING(OVERSAMPLING),
    .RAW_DEPTH(RAW_DEPTH), .RAW_AW(RAW_AW), .BLK_AW(BLK_AW)
  ) u_ctrl (
    .clk, .rst_n,
    .raw_rate_step(step_r), .source_clock_rate(rate_r),
    .in_valid, .in_ready, .in_sample_in,
    .out_valid, .out_ready, .out_block_last,
    .cmd, .raw_we, .raw_waddr, .raw_wdata, .raw_wsel_copy,
    .raw_raddr, .raw_rvalid, .tap, .blk_addr
  );

  fdr_datapath #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES), .RAW_DEPTH(RAW_DEPTH),
    .RAW_AW(RAW_AW), .BLK_AW(BLK_AW)
  ) u_dp (
    .clk, .rst_n, .cmd, .raw_we, .raw_waddr, .raw_wdata, .raw_wsel_copy,
    .raw_raddr, .raw_rvalid, .tap, .blk_addr, .sample_q(out_sample_out)
  );

endmodule

// ===== dv/tb_fir_decimating_resampler.sv =====
`timescale 1ns / 1ps

module tb_fir_decimating_resampler;
  import fdr_pkg::*;

  localparam int BLK        = 32;
  localparam int OVS        = 4;
  localparam int DEPTH      = 192;
  // Block run plus history copy, rounded up with a wide margin.
  localparam int SETTLE     = 400;
  localparam int LIMIT      = 600000;
  localparam int RANDOM_LEN = 110;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
  } filt_out_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    bit                         no_store;  // tick known to store nothing
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [2:0]                 cfg_paddr;
  logic [31:0]                cfg_pwdata;
  logic [31:0]                cfg_prdata;
  logic                       cfg_pready;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_block_last;

  fir_decimating_resampler u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_block_last(out_block_last)
  );

  // Half of the symmetric low-pass, taps 0..32, Q0.15.
  int half_taps [33] = '{
    0, 0, -17, -36, -56, -74, -90, -102, -107, -104, -92, -70, -36,
    10, 69, 141, 225, 320, 425, 539, 659, 784, 910, 1035, 1157, 1273,
    1379, 1474, 1555, 1620, 1668, 1697, 1707
  };

  // Own copy of the resampler state and registers.
  logic [REG_W-1:0]   step_reg;
  logic [REG_W-1:0]   wrap_reg;
  logic [PHASE_W-1:0] phase;
  int                 raw_hist [DEPTH];
  int                 wr_pos;

  filt_out_t  pending_out[$];
  idle_mode_e idle_mode;
  int         errors = 0;
  int         cycles = 0;
  int         ticks_sent;
  int         outs_seen = 0;
  int         blocks_seen = 0;

  stim_row_t directed [25];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint floor_div(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int tap(input int j);
    return half_taps[(j <= 32) ? j : 64 - j];
  endfunction

  // Advance the phase by one tick; on a store that fills the raw history,
  // filter, remove the block mean and queue the whole block.
  function automatic int resample_tick(input logic signed [SAMPLE_W-1:0] s);
    longint ph;
    longint acc;
    longint sum;
    longint mean;
    longint y [BLK];
    int     keep [TAPS];
    filt_out_t r;
    ph = longint'(phase) + longint'(step_reg);
    if (ph < longint'(wrap_reg)) begin
      phase = ph[PHASE_W-1:0];
      return 0;
    end
    ph = ph - longint'(wrap_reg);
    phase = ph[PHASE_W-1:0];
    if (wr_pos < DEPTH) raw_hist[wr_pos] = s;
    wr_pos++;
    if (wr_pos < DEPTH) return 0;
    sum = 0;
    for (int i = 0; i < BLK; i++) begin
      acc = 0;
      for (int j = 0; j < TAPS; j++)
        if (i * OVS + j < DEPTH) acc += longint'(raw_hist[i * OVS + j]) * tap(j);
      y[i] = sat16(floor_div(acc + 16384, 32768));
      sum += y[i];
    end
    mean = floor_div(sum + BLK / 2, BLK);
    for (int i = 0; i < BLK; i++) begin
      r.smp  = 16'(sat16(y[i] - mean));
      r.last = (i == BLK - 1);
      pending_out.push_back(r);
    end
    for (int k = 0; k < TAPS; k++) keep[k] = raw_hist[BLK * OVS + k];
    for (int k = 0; k < TAPS; k++) raw_hist[k] = keep[k];
    wr_pos = TAPS;
    return BLK;
  endfunction

  // Hold valid with the sample until the transfer; drop valid on a gap only.
  task automatic send_tick(input logic signed [SAMPLE_W-1:0] s, output int n_out);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SRC) ? 45 : (idle_mode == IDLE_BOTH) ? 25 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    n_out = resample_tick(s);
    ticks_sent++;
  endtask

  // Pause the sender until every queued result has come, then let the
  // history copy finish.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [REG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {8'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_RAW_RATE_STEP) step_reg = val;
    else wrap_reg = val;
  endtask

  task automatic random_phase(input idle_mode_e mode, input int n_items,
                              input bit mid_pause);
    int n;
    idle_mode = mode;
    for (int k = 0; k < n_items; k++) begin
      if (mid_pause && k == n_items / 2) drain();
      send_tick(16'($urandom), n);
    end
    drain();
  endtask

  // Receiver: stall at random according to the current idle mode.
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_SNK:  out_ready <= ($urandom_range(99) >= 45);
      IDLE_BOTH: out_ready <= ($urandom_range(99) >= 25);
      default:   out_ready <= 1'b1;
    endcase
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    filt_out_t e;
    if (rst_n && out_valid && out_ready) begin
      outs_seen++;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result sample_out=%0d block_last=%0b",
                 $time, out_sample_out, out_block_last);
        errors++;
      end else begin
        e = pending_out.pop_front();
        if (out_sample_out !== e.smp) begin
          $display("%0t: sample_out expected %0d actual %0d",
                   $time, e.smp, out_sample_out);
          errors++;
        end
        if (out_block_last !== e.last) begin
          $display("%0t: block_last expected %0b actual %0b",
                   $time, e.last, out_block_last);
          errors++;
        end
        if (out_block_last === 1'b1) blocks_seen++;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
      $display("tb_fir_decimating_resampler: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    idle_mode    = IDLE_NONE;
    ticks_sent   = 0;
    step_reg     = RAW_RATE_STEP_RESET;
    wrap_reg     = SOURCE_CLOCK_RATE_RESET;
    phase        = '0;
    wr_pos       = HALF_TAPS;
    foreach (raw_hist[k]) raw_hist[k] = 0;

    // Reset rates: the first nine ticks stay below the wrap and store nothing.
    directed = '{
      '{16'sh7fff, 1}, '{-16'sh8000, 1}, '{16'sh0000, 1}, '{-16'sh0001, 1},
      '{16'sh0001, 1}, '{16'sh5555, 1}, '{-16'sh5556, 1}, '{16'sh7fff, 1},
      '{-16'sh8000, 1}, '{16'sh7fff, 0}, '{-16'sh8000, 0}, '{16'sh1234, 0},
      '{-16'sh1234, 0}, '{16'sh0f0f, 0}, '{-16'sh0f10, 0}, '{16'sh00ff, 0},
      '{16'sh7f00, 0}, '{-16'sh0100, 0}, '{16'sh4000, 0}, '{-16'sh4000, 0},
      '{16'sh7fff, 0}, '{16'sh7fff, 0}, '{-16'sh8000, 0}, '{-16'sh8000, 0},
      '{16'sh0000, 0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) begin
      send_tick(directed[r].smp, n);
      if (directed[r].no_store && n != 0) begin
        $display("%0t: tick %0d expected no results, predicted %0d", $time, r, n);
        errors++;
      end
    end
    drain();

    // Largest step against a wrap of one: every tick stores and the phase
    // overflows its 25 bits.
    cfg_write(REG_RAW_RATE_STEP, 24'hffffff);
    cfg_write(REG_SOURCE_CLOCK_RATE, 24'd1);
    random_phase(IDLE_SRC, RANDOM_LEN, 1'b0);

    // Zero wrap value: a store on every tick regardless of the step.
    cfg_write(REG_RAW_RATE_STEP, 24'd1000);
    cfg_write(REG_SOURCE_CLOCK_RATE, 24'd0);
    random_phase(IDLE_SNK, RANDOM_LEN, 1'b1);

    // Smallest step against the largest wrap: nothing is stored.
    cfg_write(REG_RAW_RATE_STEP, 24'd1);
    cfg_write(REG_SOURCE_CLOCK_RATE, 24'hffffff);
    random_phase(IDLE_BOTH, 20, 1'b0);

    // Step equal to the wrap value: one store per tick.
    cfg_write(REG_RAW_RATE_STEP, 24'hffffff);
    random_phase(IDLE_NONE, RANDOM_LEN, 1'b0);

    // Step of half the wrap, but the phase carried over lies far above it: every tick stores.
    cfg_write(REG_RAW_RATE_STEP, 24'd5);
    cfg_write(REG_SOURCE_CLOCK_RATE, 24'd10);
    random_phase(IDLE_BOTH, 80, 1'b0);

    $display("Covered %0d source ticks over six rate settings, %0d results in %0d blocks,",
             ticks_sent, outs_seen, blocks_seen);
    $display("with sender gaps, receiver stalls and drained pauses; %0d mismatches.", errors);
    if (errors == 0 && pending_out.size() == 0) begin
      $display("tb_fir_decimating_resampler: PASS");
    end else begin
      $display("tb_fir_decimating_resampler: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fdr_pkg.sv
src/fdr_datapath.sv
src/fdr_ctrl.sv
src/fir_decimating_resampler.sv
dv/tb_fir_decimating_resampler.sv
